// ===== hdl/rbb_pkg.sv =====
package rbb_pkg;
  localparam int MaxPixels = 65536;
  localparam int PixAw = 16;
  localparam int MaxBall = 4096;
  localparam int BallAw = 12;
  localparam int MaxWidth = 1024;
  localparam int ValW = 25;
  localparam int AccW = 27;
  localparam logic signed [ValW-1:0] ValMax = 25'sd16776960;
  localparam logic signed [ValW-1:0] ValMin = -25'sd16776960;

  localparam logic [1:0] ReqBall = 2'd0;
  localparam logic [1:0] ReqPixel = 2'd1;
  localparam logic [1:0] ReqStart = 2'd2;
  localparam logic [1:0] ReqRead = 2'd3;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegBall = 2'd2;

  function automatic logic signed [ValW-1:0] sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(ValMax);
    lo = AccW'(ValMin);
    if (v > hi) sat = ValMax;
    else if (v < lo) sat = ValMin;
    else sat = v[ValW-1:0];
  endfunction
endpackage

// ===== hdl/rbb_alu.sv =====
// Shared unit: one subtract-or-add with saturation and compare per cycle.
module rbb_alu import rbb_pkg::*; (
  input  logic                   add,
  input  logic signed [AccW-1:0] a,
  input  logic signed [ValW-1:0] b,
  input  logic signed [AccW-1:0] cmp,
  output logic signed [AccW-1:0] sum,
  output logic signed [ValW-1:0] res,
  output logic                   less
);
  always_comb begin
    sum = add ? (a + AccW'(b)) : (a - AccW'(b));
    res = sat(sum);
    less = add ? (cmp < AccW'(res)) : (sum < cmp);
  end
endmodule

// ===== hdl/rolling_ball_background.sv =====
// channel | valid   | stall   | payload
// in      | valid   | stall   | req_type, index, value
// out     | o_valid | o_stall | background
// Loads: one transfer per cycle while stall is low. A read stalls input through
//   its fetch state S_RDW, then for as long as its result is held.
// Start: W*H clear states, then per centre a setup, a min pass (read, min)
//   and a raise pass (read, max, writeback) per covered pixel, a step; stall high meanwhile.
// Reset and each config write: input stalls while the height limit settles.
// Reset clears the sequencer and config only; memories keep contents.
module rolling_ball_background import rbb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid,
  output logic                   stall,
  input  logic [1:0]             req_type,
  input  logic [15:0]            index,
  input  logic signed [ValW-1:0] value,
  output logic                   o_valid,
  input  logic                   o_stall,
  output logic signed [ValW-1:0] background,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CEN, S_RD, S_MIN, S_RD2, S_MAX, S_WB, S_NEXT, S_RDW
  } state_t;

  state_t state;
  logic [10:0] image_width, image_height;
  logic [5:0] ball_width;

  logic signed [ValW-1:0] src_mem [MaxPixels];
  logic signed [ValW-1:0] bg_mem [MaxPixels];
  logic signed [ValW-1:0] ball_mem [MaxBall];

  // geometry
  logic [11:0] w, h;
  logic [16:0] npix;
  logic [5:0] r;
  logic [16:0] cnt;
  logic signed [12:0] cx, cy, px, py, x0, xe, y0, ye;
  logic signed [12:0] rs, ws, hs, x0_n, xe_n, y0_n, ye_n;
  logic signed [13:0] bx, by;
  logic signed [AccW-1:0] z;
  logic signed [ValW-1:0] sdat, bdat, gdat, ball_b;
  logic signed [16:0] pix_lin;
  logic [PixAw-1:0] paddr_pix, rd_addr;
  logic [17:0] bidx;
  logic bvalid;
  logic signed [AccW-1:0] alu_sum;
  logic signed [ValW-1:0] alu_res;
  logic alu_less, alu_add;
  logic signed [ValW-1:0] in_sat;
  // height limit: largest h <= image_height with w*h inside the store
  logic dims_busy;
  logic [3:0] dbit;
  logic [11:0] h_try;
  logic [23:0] h_prod;

  assign pready = 1'b1;
  assign stall = (state != S_IDLE) || (o_valid && o_stall) || dims_busy;

  always_comb begin
    case (paddr[3:2])
      RegWidth:  prdata = {21'd0, image_width};
      RegHeight: prdata = {21'd0, image_height};
      RegBall:   prdata = {26'd0, ball_width};
      default:   prdata = 32'd0;
    endcase
  end

  // width clamps to the row limit; height found bit by bit after config
  assign w = (image_width > 11'(MaxWidth)) ? 12'(MaxWidth) : {1'b0, image_width};
  assign h_try = h | (12'd1 << dbit);
  assign h_prod = 24'(w) * 24'(h_try);
  assign npix = 17'(w) * 17'(h);

  assign in_sat = (value > ValMax) ? ValMax : ((value < ValMin) ? ValMin : value);
  assign r = {1'b0, ball_width[5:1]};
  assign rs = 13'(r);
  assign ws = 13'(w);
  assign hs = 13'(h);
  assign x0_n = (cx - rs < 13'sd0) ? 13'sd0 : cx - rs;
  assign xe_n = (cx + rs >= ws) ? ws - 13'sd1 : cx + rs;
  assign y0_n = (cy - rs < 13'sd0) ? 13'sd0 : cy - rs;
  assign ye_n = (cy + rs >= hs) ? hs - 13'sd1 : cy + rs;
  assign bidx = 18'(bx) + 18'(by) * 18'(ball_width);
  assign bvalid = (bx >= 0) && (by >= 0) && (bidx < 18'(MaxBall));
  assign ball_b = bvalid ? bdat : '0;
  assign pix_lin = 17'(px) + 17'(py) * 17'(ws);
  assign paddr_pix = pix_lin[PixAw-1:0];
  assign alu_add = (state == S_MAX);

  rbb_alu u_alu (.add(alu_add), .a((state == S_MAX) ? z : AccW'(sdat)),
    .b(ball_b), .cmp((state == S_MAX) ? AccW'(gdat) : z),
    .sum(alu_sum), .res(alu_res), .less(alu_less));

  always_ff @(posedge clk) begin
    if (valid && !stall && req_type == ReqBall && index < 16'(MaxBall))
      ball_mem[index[BallAw-1:0]] <= in_sat;
    if (valid && !stall && req_type == ReqPixel) src_mem[index] <= in_sat;
    if (state == S_CLR) bg_mem[cnt[PixAw-1:0]] <= ValMin;
    if (state == S_WB) bg_mem[paddr_pix] <= gdat;
    sdat <= src_mem[paddr_pix];
    gdat <= (state == S_MAX && alu_less) ? alu_res : bg_mem[rd_addr];
    if (state != S_MAX) bdat <= ball_mem[bidx[BallAw-1:0]];
  end
  assign rd_addr = (state == S_IDLE) ? index : paddr_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      o_valid <= 1'b0;
      image_width <= 11'd256;
      image_height <= 11'd256;
      ball_width <= 6'd1;
      dims_busy <= 1'b1;
      dbit <= 4'd10;
      h <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          RegWidth:  image_width <= pwdata[10:0];
          RegHeight: image_height <= pwdata[10:0];
          RegBall:   ball_width <= pwdata[5:0];
          default:   ;
        endcase
        dims_busy <= 1'b1;
        dbit <= 4'd10;
        h <= '0;
      end else if (dims_busy) begin
        if (h_try <= {1'b0, image_height} && h_prod <= 24'(MaxPixels)) h <= h_try;
        if (dbit == 4'd0) dims_busy <= 1'b0;
        else dbit <= dbit - 4'd1;
      end
      if (o_valid && !o_stall) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid && !stall && req_type == ReqStart && w != 0 && h != 0) begin
            state <= S_CLR;
            cnt <= '0;
          end else if (valid && !stall && req_type == ReqRead) begin
            state <= S_RDW;
            cnt <= {16'd0, (17'(index) < npix)};
          end
        end
        S_RDW: begin
          o_valid <= 1'b1;
          background <= cnt[0] ? gdat : '0;
          state <= S_IDLE;
        end
        S_CLR: begin
          if (cnt + 17'd1 >= npix) begin
            state <= S_CEN;
            cy <= -rs;
            cx <= -rs;
          end
          cnt <= cnt + 17'd1;
        end
        S_CEN: begin
          x0 <= x0_n;
          xe <= xe_n;
          y0 <= y0_n;
          ye <= ye_n;
          px <= x0_n;
          py <= y0_n;
          bx <= 14'(x0_n - cx + rs);
          by <= 14'(y0_n - cy + rs);
          z <= AccW'(ValMax);
          cnt[0] <= 1'b0;
          state <= S_RD;
        end
        S_RD: state <= cnt[0] ? S_MAX : S_MIN;
        S_MIN, S_WB: begin
          if (state == S_MIN && alu_less) z <= alu_sum;
          if (px < xe) begin
            px <= px + 1; bx <= bx + 1; state <= S_RD;
          end else if (py < ye) begin
            px <= x0; bx <= bx - 14'(xe - x0); py <= py + 1; by <= by + 1;
            state <= S_RD;
          end else if (state == S_MIN) begin
            px <= x0; py <= y0;
            bx <= bx - 14'(xe - x0); by <= by - 14'(ye - y0);
            cnt[0] <= 1'b1; state <= S_RD;
          end else state <= S_NEXT;
        end
        S_MAX: state <= S_WB;
        S_NEXT: begin
          if (cx + 13'sd1 < ws + rs) begin
            cx <= cx + 13'sd1; state <= S_CEN;
          end else if (cy + 13'sd1 < hs + rs) begin
            cx <= -rs; cy <= cy + 13'sd1; state <= S_CEN;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> stall) else $error("accept while busy");
  a_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_RDW |=> o_valid) else $error("read lost");
  a_wb: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> $past(state) == S_MAX) else $error("bad writeback");
`endif
endmodule
